### design/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg: shared types for the indexed list
// Action and status codes, controller states and the command and flag
// structs passed between controller and datapath.
// ----------------------------------------------------------------------------
package ilist_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    ACT_APPEND      = 3'd0,
    ACT_REMOVE_LAST = 3'd1,
    ACT_INSERT_AT   = 3'd2,
    ACT_REPLACE_AT  = 3'd3,
    ACT_REMOVE_AT   = 3'd4,
    ACT_READ        = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_RESP = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic    load;
    logic    use_count;
    logic    wr;
    logic    shift_up;
    logic    shift_down;
    logic    inc;
    logic    dec;
    logic    rd;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic in_range;
  } dp_flags_t;

endpackage

### design/ilist_ctrl.sv
// ----------------------------------------------------------------------------
// ilist_ctrl: request controller
// Decodes the action against the list flags, issues one datapath command
// per accepted item and marks the result cycle.
// ----------------------------------------------------------------------------
module ilist_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         action,
  input  ilist_pkg::dp_flags_t flags,
  output ilist_pkg::dp_cmd_t cmd,
  output logic               busy,
  output logic               done
);

  ilist_pkg::ctrl_state_t state, state_next;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilist_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = accept ? ilist_pkg::CS_RESP : ilist_pkg::CS_IDLE;
    done       = (state == ilist_pkg::CS_RESP);

    cmd            = '0;
    cmd.load       = accept;
    cmd.status     = ilist_pkg::STATUS_OK;
    unique case (ilist_pkg::action_t'(action))
      ilist_pkg::ACT_APPEND: begin
        if (flags.full) begin
          cmd.status = ilist_pkg::STATUS_FULL;
        end else begin
          cmd.wr        = 1'b1;
          cmd.use_count = 1'b1;
          cmd.inc       = 1'b1;
        end
      end
      ilist_pkg::ACT_REMOVE_LAST: begin
        if (flags.empty) begin
          cmd.status = ilist_pkg::STATUS_EMPTY;
        end else begin
          cmd.dec = 1'b1;
        end
      end
      ilist_pkg::ACT_INSERT_AT: begin
        if (!flags.in_range) begin
          cmd.status = ilist_pkg::STATUS_RANGE;
        end else if (flags.full) begin
          cmd.status = ilist_pkg::STATUS_FULL;
        end else begin
          cmd.wr       = 1'b1;
          cmd.shift_up = 1'b1;
          cmd.inc      = 1'b1;
        end
      end
      ilist_pkg::ACT_REPLACE_AT: begin
        if (!flags.in_range) begin
          cmd.status = ilist_pkg::STATUS_RANGE;
        end else begin
          cmd.wr = 1'b1;
        end
      end
      ilist_pkg::ACT_REMOVE_AT: begin
        if (flags.empty) begin
          cmd.status = ilist_pkg::STATUS_EMPTY;
        end else if (!flags.in_range) begin
          cmd.status = ilist_pkg::STATUS_RANGE;
        end else begin
          cmd.shift_down = 1'b1;
          cmd.dec        = 1'b1;
        end
      end
      ilist_pkg::ACT_READ: begin
        if (!flags.in_range) begin
          cmd.status = ilist_pkg::STATUS_RANGE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      default: begin
        cmd.status = ilist_pkg::STATUS_RANGE;
      end
    endcase
  end

endmodule

### design/ilist_dp.sv
// ----------------------------------------------------------------------------
// ilist_dp: list datapath
// Row of entry registers that shift up or down, the entry
// count, and the registered result of each item.
// ----------------------------------------------------------------------------
module ilist_dp #(
  parameter int CAPACITY = ilist_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ilist_pkg::dp_cmd_t            cmd,
  input  logic [4:0]                    index,
  input  logic signed [31:0]            value,
  output ilist_pkg::dp_flags_t          flags,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  output logic signed [31:0]            read_data,
  output logic [4:0]                    entry_count,
  output logic [1:0]                    status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > 5) ? CW : 5;

  logic signed [31:0] entries [CAPACITY];
  logic [CW-1:0]      count_next;
  logic [XW-1:0]      index_x;
  logic [XW-1:0]      count_x;
  logic [CW-1:0]      pos;
  logic [IW-1:0]      rd_addr;

  assign index_x = XW'(index);
  assign count_x = XW'(count);

  assign flags.in_range = (index_x < count_x);
  assign flags.full     = (count == CW'(CAPACITY));
  assign flags.empty    = (count == '0);

  assign pos     = cmd.use_count ? count : CW'(index_x);
  assign rd_addr = pos[IW-1:0];

  always_comb begin
    count_next = count;
    if (cmd.inc) begin
      count_next = count + CW'(1);
    end else if (cmd.dec) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= count_next;
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [31:0] below;
    logic signed [31:0] above;

    if (k > 0) begin : g_below
      assign below = entries[k-1];
    end else begin : g_no_below
      assign below = value;
    end

    if (k < CAPACITY - 1) begin : g_above
      assign above = entries[k+1];
    end else begin : g_no_above
      assign above = entries[k];
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        if (cmd.wr && (CW'(k) == pos)) begin
          entries[k] <= value;
        end else if (cmd.shift_up && (CW'(k) > pos)) begin
          entries[k] <= below;
        end else if (cmd.shift_down && (CW'(k) >= pos)) begin
          entries[k] <= above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      read_data   <= cmd.rd ? entries[rd_addr] : 32'sd0;
      entry_count <= 5'(count_next);
      status      <= cmd.status;
    end
  end

endmodule

### design/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete: fixed-capacity ordered list of signed words
// Append, remove last, insert at, replace at, remove at and read, one
// request per item, with one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Drive action, index and value and raise start; the item is taken at a
//   rising edge with start high and busy low. busy stays low, so a new item
//   may be taken every cycle.
//   The result (read_data, entry_count, status) shows on the cycle after
//   the item is taken, marked by done for exactly one cycle. Throughput is
//   one item per cycle: the entry row shifts in the same edge that takes
//   the item.
//   The receiver cannot stall; a result not taken in its done cycle is
//   gone.
//   Rejected requests (status range, full or empty) leave the list as it
//   was and return read_data zero.
//   Reset empties the list at once; entry contents are undefined until
//   written, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete #(
  parameter int CAPACITY = ilist_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [4:0]         index,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] read_data,
  output logic [4:0]         entry_count,
  output logic [1:0]         status
);

  ilist_pkg::dp_cmd_t            cmd;
  ilist_pkg::dp_flags_t          flags;
  logic [$clog2(CAPACITY+1)-1:0] count;

  ilist_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .flags  (flags),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ilist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .index       (index),
    .value       (value),
    .flags       (flags),
    .count       (count),
    .read_data   (read_data),
    .entry_count (entry_count),
    .status      (status)
  );

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after accepted item");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without accepted item");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ilist_pkg::STATUS_OK)) |-> (count == $past(count)))
    else $error("rejected item changed the count");

  a_data_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (read_data != 32'sd0)) |-> (status == ilist_pkg::STATUS_OK))
    else $error("read data on rejected item");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> (32'(count) <= CAPACITY))
    else $error("count beyond capacity");

endmodule

### tb/indexed_list_insert_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_tb: self-checking bench for the indexed list
// Sends list requests through the start/busy handshake and predicts each
// result from a local copy of the list. Directed items cover the empty and
// full rejections, the unused action codes and shifting. Random items then
// walk the count between empty and full under several sender gap rates.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_tb;

  localparam int LIST_DEPTH = ilist_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [2:0] ACT_UNUSED_SIX = 3'd6;
  localparam logic [2:0] ACT_UNUSED_SEVEN = 3'd7;

  typedef struct {
    logic signed [31:0]  data;
    logic [4:0]          count;
    ilist_pkg::status_t  stat;
  } list_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         action;
  logic [4:0]         index;
  logic signed [31:0] value;
  logic               done;
  logic signed [31:0] read_data;
  logic [4:0]         entry_count;
  logic [1:0]         status;

  logic [31:0]  list_words [LIST_DEPTH];
  int           word_count;
  list_result_t pending_results[$];
  int           sender_idle_pct;
  int           fail_count;
  int           cycle_count;
  int           items_sent;
  int           results_checked;
  int           status_tally [4];
  int           full_hits;
  int           empty_hits;

  indexed_list_insert_delete i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .index       (index),
    .value       (value),
    .done        (done),
    .read_data   (read_data),
    .entry_count (entry_count),
    .status      (status)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("indexed_list_insert_delete test failed");
      $finish;
    end
  end

  function automatic list_result_t apply_list_request(logic [2:0] act, logic [4:0] idx,
                                                      logic [31:0] val);
    list_result_t res;
    logic         in_range;
    res.data = '0;
    res.stat = ilist_pkg::STATUS_OK;
    in_range = (int'(idx) < word_count);
    case (act)
      ilist_pkg::ACT_APPEND: begin
        if (word_count >= LIST_DEPTH) begin
          res.stat = ilist_pkg::STATUS_FULL;
        end else begin
          list_words[word_count] = val;
          word_count++;
        end
      end
      ilist_pkg::ACT_REMOVE_LAST: begin
        if (word_count == 0) res.stat = ilist_pkg::STATUS_EMPTY;
        else word_count--;
      end
      ilist_pkg::ACT_INSERT_AT: begin
        if (!in_range) begin
          res.stat = ilist_pkg::STATUS_RANGE;
        end else if (word_count >= LIST_DEPTH) begin
          res.stat = ilist_pkg::STATUS_FULL;
        end else begin
          for (int k = word_count; k > int'(idx); k--) list_words[k] = list_words[k-1];
          list_words[idx] = val;
          word_count++;
        end
      end
      ilist_pkg::ACT_REPLACE_AT: begin
        if (!in_range) res.stat = ilist_pkg::STATUS_RANGE;
        else list_words[idx] = val;
      end
      ilist_pkg::ACT_REMOVE_AT: begin
        if (word_count == 0) begin
          res.stat = ilist_pkg::STATUS_EMPTY;
        end else if (!in_range) begin
          res.stat = ilist_pkg::STATUS_RANGE;
        end else begin
          for (int k = idx; k + 1 < word_count; k++) list_words[k] = list_words[k+1];
          word_count--;
        end
      end
      ilist_pkg::ACT_READ: begin
        if (!in_range) res.stat = ilist_pkg::STATUS_RANGE;
        else res.data = list_words[idx];
      end
      default: res.stat = ilist_pkg::STATUS_RANGE;
    endcase
    res.count = word_count[4:0];
    return res;
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] edge_words [4];
    edge_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    if ($urandom_range(9) == 0) return edge_words[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic send_item(logic [2:0] act, logic [4:0] idx, logic [31:0] val);
    list_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    action <= act;
    index  <= idx;
    value  <= val;
    do @(posedge clk); while (busy);
    res = apply_list_request(act, idx, val);
    pending_results.push_back(res);
    items_sent++;
    status_tally[res.stat]++;
    if (res.stat == ilist_pkg::STATUS_OK && word_count == LIST_DEPTH &&
        (act == ilist_pkg::ACT_APPEND || act == ilist_pkg::ACT_INSERT_AT)) full_hits++;
    if (res.stat == ilist_pkg::STATUS_OK && word_count == 0 &&
        (act == ilist_pkg::ACT_REMOVE_LAST || act == ilist_pkg::ACT_REMOVE_AT)) empty_hits++;
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: read_data %0d count %0d status %0d",
                 $time, read_data, entry_count, status);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (read_data !== exp_res.data) begin
          $display("%0t: read_data expected %0d actual %0d", $time, exp_res.data, read_data);
          fail_count++;
        end
        if (entry_count !== exp_res.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, exp_res.count,
                   entry_count);
          fail_count++;
        end
        if (status !== exp_res.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.stat, status);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_list_rejects();
    send_item(ilist_pkg::ACT_REMOVE_LAST, 5'd0, 32'd0);
    send_item(ilist_pkg::ACT_REMOVE_AT, 5'd0, 32'd0);
    send_item(ilist_pkg::ACT_READ, 5'd0, 32'd0);
    send_item(ACT_UNUSED_SIX, 5'd31, 32'hffff_ffff);
    send_item(ACT_UNUSED_SEVEN, 5'd0, 32'h0000_0000);
  endtask

  task automatic test_fill_to_capacity();
    send_item(ilist_pkg::ACT_APPEND, 5'd0, 32'h8000_0000);
    send_item(ilist_pkg::ACT_APPEND, 5'd0, 32'h7fff_ffff);
    send_item(ilist_pkg::ACT_APPEND, 5'd0, 32'hffff_ffff);
    send_item(ilist_pkg::ACT_APPEND, 5'd0, 32'h0000_0000);
    for (int n = 4; n < LIST_DEPTH; n++) send_item(ilist_pkg::ACT_APPEND, 5'd0, $urandom);
    send_item(ilist_pkg::ACT_APPEND, 5'd0, $urandom);
    send_item(ilist_pkg::ACT_INSERT_AT, 5'd5, $urandom);
  endtask

  task automatic test_shift_edits();
    send_item(ilist_pkg::ACT_REMOVE_AT, 5'd0, 32'd0);
    send_item(ilist_pkg::ACT_INSERT_AT, 5'd0, 32'h1234_5678);
  endtask

  task automatic test_random_edits(int num_items, int idle_pct);
    bit          grow;
    int          run_left;
    int          r;
    logic [2:0]  act;
    logic [4:0]  idx;
    sender_idle_pct = idle_pct;
    grow = 1'b1;
    run_left = $urandom_range(20, 60);
    for (int n = 0; n < num_items; n++) begin
      if (run_left == 0) begin
        grow = !grow;
        run_left = $urandom_range(20, 60);
      end
      run_left--;
      r = $urandom_range(99);
      if (grow) begin
        if (r < 30) act = ilist_pkg::ACT_APPEND;
        else if (r < 55) act = ilist_pkg::ACT_INSERT_AT;
        else if (r < 63) act = ilist_pkg::ACT_REMOVE_LAST;
        else if (r < 73) act = ilist_pkg::ACT_REMOVE_AT;
        else if (r < 83) act = ilist_pkg::ACT_REPLACE_AT;
        else if (r < 98) act = ilist_pkg::ACT_READ;
        else act = r[0] ? ACT_UNUSED_SEVEN : ACT_UNUSED_SIX;
      end else begin
        if (r < 10) act = ilist_pkg::ACT_APPEND;
        else if (r < 18) act = ilist_pkg::ACT_INSERT_AT;
        else if (r < 43) act = ilist_pkg::ACT_REMOVE_LAST;
        else if (r < 68) act = ilist_pkg::ACT_REMOVE_AT;
        else if (r < 78) act = ilist_pkg::ACT_REPLACE_AT;
        else if (r < 98) act = ilist_pkg::ACT_READ;
        else act = r[0] ? ACT_UNUSED_SEVEN : ACT_UNUSED_SIX;
      end
      if (word_count > 0 && $urandom_range(99) < 85) idx = 5'($urandom_range(word_count - 1));
      else idx = 5'($urandom_range(31));
      send_item(act, idx, pick_word());
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    action          = '0;
    index           = '0;
    value           = '0;
    word_count      = 0;
    fail_count      = 0;
    cycle_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    full_hits       = 0;
    empty_hits      = 0;
    status_tally    = '{default: 0};
    sender_idle_pct = 11;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list_rejects();
    test_fill_to_capacity();
    test_shift_edits();
    wait_for_drain();
    test_random_edits(410, 11);
    wait_for_drain();
    test_random_edits(410, 62);
    wait_for_drain();
    test_random_edits(410, 0);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      fail_count++;
    end
    $display("Sent %0d requests, checked %0d results: %0d ok, %0d range, %0d full, %0d empty.",
             items_sent, results_checked, status_tally[ilist_pkg::STATUS_OK],
             status_tally[ilist_pkg::STATUS_RANGE], status_tally[ilist_pkg::STATUS_FULL],
             status_tally[ilist_pkg::STATUS_EMPTY]);
    $display("List filled to capacity %0d times and drained to empty %0d times.",
             full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("indexed_list_insert_delete test passed");
    end else begin
      $display("indexed_list_insert_delete test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/ilist_pkg.sv
design/ilist_ctrl.sv
design/ilist_dp.sv
design/indexed_list_insert_delete.sv
tb/indexed_list_insert_delete_tb.sv
